// ----- sv/tccc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the text console cursor controller.
// No dependencies; every other file refers to this package by scoped names.
package tccc_pkg;

    // input operations
    localparam logic [1:0] OP_PUT     = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_ENABLE  = 2'd2;
    localparam logic [1:0] OP_DISABLE = 2'd3;

    // render commands
    localparam logic [1:0] CMD_INVERT = 2'd0;
    localparam logic [1:0] CMD_DRAW   = 2'd1;
    localparam logic [1:0] CMD_SCROLL = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ACTIVE  = 2'd0;
    localparam logic [1:0] REG_COLUMNS = 2'd1;
    localparam logic [1:0] REG_ROWS    = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int COLS_W     = 10;
    localparam int ROWS_W     = 9;

    localparam logic [COLS_W-1:0] COLUMNS_RST = 10'd80;
    localparam logic [ROWS_W-1:0] ROWS_RST    = 9'd25;

    localparam int MAX_COLUMNS_DEF = 512;
    localparam int MAX_ROWS_DEF    = 256;

    // character codes
    localparam logic [7:0] CHAR_BS = 8'd8;
    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd127;

    localparam logic [6:0] GLYPH_SPACE   = 7'd32;
    localparam logic [6:0] GLYPH_UNKNOWN = 7'd63;

    localparam int CELL_COL_W = 9;
    localparam int CELL_ROW_W = 8;
    localparam int GLYPH_W    = 7;
    localparam int SLOTS      = 4;
    localparam int SLOT_IDX_W = 2;
    localparam int SLOT_CNT_W = 3;

    typedef struct packed {
        logic                  active;
        logic [COLS_W-1:0]     columns;
        logic [ROWS_W-1:0]     rows;
    } cfg_t;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [CELL_COL_W-1:0] col;
        logic [CELL_ROW_W-1:0] row;
        logic [GLYPH_W-1:0]    glyph;
    } cmd_t;

    typedef struct packed {
        cmd_t [SLOTS-1:0]      slot;
        logic [SLOT_CNT_W-1:0] count;
    } bundle_t;

endpackage

// ----- sv/text_console_cursor_controller.sv -----
`timescale 1ns / 1ps
// Text console cursor controller: top level with configuration registers.
// The first command of an item passes the input register, the command list buffer and the output register.
// Throughput: one item per cycle while each causes at most one command and m_tready is high;
// an item causing n commands (n <= 4) holds the result channel, one command a cycle while m_tready is high.
// Reset (aresetn, synchronous): cursor at 0,0, enabled, hidden; console inactive, 80x25.
module text_console_cursor_controller #(
    parameter int MAX_COLUMNS = tccc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tccc_pkg::MAX_ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] char_code
    input  logic [1:0]                        s_tuser,   // [1:0] operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // [8:0] cell_column, [16:9] cell_row,
                                                         // [23:17] glyph
    output logic [1:0]                        m_tuser,   // [1:0] command
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tccc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tccc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tccc_pkg::cfg_t    cfg_reg;
    tccc_pkg::bundle_t bundle;
    logic              push;
    logic              bundle_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active  <= 1'b0;
            cfg_reg.columns <= tccc_pkg::COLUMNS_RST;
            cfg_reg.rows    <= tccc_pkg::ROWS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tccc_pkg::REG_ACTIVE:  cfg_reg.active  <= cfg_data[0];
                tccc_pkg::REG_COLUMNS: cfg_reg.columns <= cfg_data[tccc_pkg::COLS_W-1:0];
                tccc_pkg::REG_ROWS:    cfg_reg.rows    <= cfg_data[tccc_pkg::ROWS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tccc_core #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_op         (s_tuser),
        .s_char       (s_tdata),
        .bundle       (bundle),
        .push         (push),
        .bundle_ready (bundle_ready)
    );

    tccc_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bundle       (bundle),
        .push         (push),
        .bundle_ready (bundle_ready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

`ifndef SYNTHESIS
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> bundle_ready)
        else $error("command list pushed into a full buffer");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (bundle.count != 3'd0 && bundle.count <= 3'd4))
        else $error("command list count out of range");

    a_clear_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == tccc_pkg::CMD_CLEAR || m_tuser == tccc_pkg::CMD_SCROLL))
        |-> (m_tdata == 24'd0))
        else $error("scroll or clear carries a cell or glyph");

    a_glyph_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == tccc_pkg::CMD_INVERT) |-> (m_tdata[23:17] == 7'd0))
        else $error("invert carries a glyph");
`endif

endmodule

// ----- sv/tccc_core.sv -----
`timescale 1ns / 1ps
// Input register, cursor state and the per-item command list builder.
// Depends on tccc_pkg; feeds its command list to tccc_emit.
module tccc_core #(
    parameter int MAX_COLUMNS = tccc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tccc_pkg::MAX_ROWS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tccc_pkg::cfg_t    cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        s_op,
    input  logic [7:0]        s_char,
    output tccc_pkg::bundle_t bundle,
    output logic              push,
    input  logic              bundle_ready
);

    localparam int ColLim = (MAX_COLUMNS < 1023) ? MAX_COLUMNS : 1023;
    localparam int RowLim = (MAX_ROWS < 511) ? MAX_ROWS : 511;
    localparam int ColW   = (ColLim > 1) ? $clog2(ColLim) : 1;
    localparam int RowW   = (RowLim > 1) ? $clog2(RowLim) : 1;
    localparam logic [tccc_pkg::COLS_W-1:0] ColCap = tccc_pkg::COLS_W'(ColLim);
    localparam logic [tccc_pkg::ROWS_W-1:0] RowCap = tccc_pkg::ROWS_W'(RowLim);

    logic            in_valid_reg;
    logic [1:0]      in_op_reg;
    logic [7:0]      in_char_reg;
    logic [ColW-1:0] col_reg, col_next;
    logic [RowW-1:0] row_reg, row_next;
    logic            enabled_reg, enabled_next;
    logic            visible_reg, visible_next;
    logic            take;

    tccc_pkg::cmd_t [tccc_pkg::SLOTS-1:0] cand;
    logic [tccc_pkg::SLOTS-1:0]           cand_en;

    assign take     = in_valid_reg && bundle_ready;
    assign s_tready = !in_valid_reg || take;

    always_comb begin
        logic [tccc_pkg::COLS_W-1:0]     eff_cols;
        logic [tccc_pkg::ROWS_W-1:0]     eff_rows;
        logic [ColW:0]                   col_inc;
        logic [RowW:0]                   row_inc;
        logic                            col_wrap;
        logic                            row_full;
        logic [ColW-1:0]                 col_bs;
        logic [tccc_pkg::GLYPH_W-1:0]    glyph_map;
        logic [tccc_pkg::SLOT_CNT_W-1:0] cnt;

        eff_cols  = (cfg.columns < ColCap) ? cfg.columns : ColCap;
        eff_rows  = (cfg.rows < RowCap) ? cfg.rows : RowCap;
        col_inc   = {1'b0, col_reg} + 1'b1;
        row_inc   = {1'b0, row_reg} + 1'b1;
        col_wrap  = 11'(col_inc) >= 11'(eff_cols);
        row_full  = 10'(row_inc) >= 10'(eff_rows);
        col_bs    = (col_reg != '0) ? col_reg - 1'b1 : col_reg;
        glyph_map = (in_char_reg < tccc_pkg::PRINT_LO || in_char_reg > tccc_pkg::PRINT_HI)
                  ? tccc_pkg::GLYPH_UNKNOWN : in_char_reg[6:0];

        col_next     = col_reg;
        row_next     = row_reg;
        enabled_next = enabled_reg;
        visible_next = visible_reg;
        cand         = '0;
        cand_en      = '0;

        // hide at the old cell
        cand[0].cmd = tccc_pkg::CMD_INVERT;
        cand[0].col = tccc_pkg::CELL_COL_W'(col_reg);
        cand[0].row = tccc_pkg::CELL_ROW_W'(row_reg);
        cand[2].cmd = tccc_pkg::CMD_SCROLL;
        cand[3].cmd = tccc_pkg::CMD_INVERT;

        case (in_op_reg)
            tccc_pkg::OP_PUT: begin
                if (cfg.active) begin
                    cand_en[0] = enabled_reg && visible_reg;
                    cand[1].cmd = tccc_pkg::CMD_DRAW;
                    cand[1].row = tccc_pkg::CELL_ROW_W'(row_reg);
                    case (in_char_reg)
                        tccc_pkg::CHAR_CR: begin
                        end
                        tccc_pkg::CHAR_LF: begin
                            col_next   = '0;
                            cand_en[2] = row_full;
                            row_next   = row_full ? row_reg : RowW'(row_inc);
                        end
                        tccc_pkg::CHAR_BS: begin
                            cand_en[1]    = 1'b1;
                            cand[1].col   = tccc_pkg::CELL_COL_W'(col_bs);
                            cand[1].glyph = tccc_pkg::GLYPH_SPACE;
                            col_next      = col_bs;
                        end
                        default: begin
                            cand_en[1]    = 1'b1;
                            cand[1].col   = tccc_pkg::CELL_COL_W'(col_reg);
                            cand[1].glyph = glyph_map;
                            if (col_wrap) begin
                                col_next   = '0;
                                cand_en[2] = row_full;
                                row_next   = row_full ? row_reg : RowW'(row_inc);
                            end else begin
                                col_next = ColW'(col_inc);
                            end
                        end
                    endcase
                    if (enabled_reg) begin
                        cand_en[3]   = 1'b1;
                        visible_next = 1'b1;
                    end
                end
            end
            tccc_pkg::OP_CLEAR: begin
                if (cfg.active) begin
                    cand_en[1]   = 1'b1;
                    cand[1].cmd  = tccc_pkg::CMD_CLEAR;
                    col_next     = '0;
                    row_next     = '0;
                    cand_en[3]   = enabled_reg;
                    visible_next = enabled_reg;
                end
            end
            tccc_pkg::OP_ENABLE: begin
                enabled_next = 1'b1;
                if (!visible_reg) begin
                    cand_en[3]   = cfg.active;
                    visible_next = 1'b1;
                end
            end
            default: begin
                if (enabled_reg && visible_reg) begin
                    cand_en[0]   = cfg.active;
                    visible_next = 1'b0;
                end
                enabled_next = 1'b0;
            end
        endcase

        // show at the new cell
        cand[3].col = tccc_pkg::CELL_COL_W'(col_next);
        cand[3].row = tccc_pkg::CELL_ROW_W'(row_next);

        // pack the enabled commands in order
        bundle.slot = '0;
        cnt         = '0;
        for (int i = 0; i < tccc_pkg::SLOTS; i++) begin
            if (cand_en[i]) begin
                bundle.slot[cnt[tccc_pkg::SLOT_IDX_W-1:0]] = cand[i];
                cnt = cnt + 1'b1;
            end
        end
        bundle.count = cnt;
    end

    assign push = take && (bundle.count != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            enabled_reg  <= 1'b1;
            visible_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (take) begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                enabled_reg <= enabled_next;
                visible_reg <= visible_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_op;
            in_char_reg <= s_char;
        end
    end

endmodule

// ----- sv/tccc_emit.sv -----
`timescale 1ns / 1ps
// Command list buffer and output register; sends one command per cycle while m_tready is high.
// Depends on tccc_pkg; takes its command lists from tccc_core.
module tccc_emit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tccc_pkg::bundle_t                   bundle,
    input  logic                                push,
    output logic                                bundle_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tccc_pkg::CELL_COL_W+tccc_pkg::CELL_ROW_W+tccc_pkg::GLYPH_W-1:0] m_tdata,
    output logic [1:0]                          m_tuser,
    output logic                                m_tlast
);

    tccc_pkg::bundle_t                 bundle_reg;
    logic                              bvalid_reg;
    logic [tccc_pkg::SLOT_IDX_W-1:0]   idx_reg;
    logic                              m_valid_reg;
    tccc_pkg::cmd_t                    m_cmd_reg;
    logic                              m_last_reg;
    logic                              out_free;
    logic                              load;
    logic                              bundle_last;

    assign out_free     = !m_valid_reg || m_tready;
    assign load         = bvalid_reg && out_free;
    assign bundle_last  = tccc_pkg::SLOT_CNT_W'(idx_reg) == (bundle_reg.count - 1'b1);
    assign bundle_ready = !bvalid_reg || (load && bundle_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bvalid_reg  <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                bvalid_reg <= 1'b1;
                idx_reg    <= '0;
            end else if (load) begin
                if (bundle_last) begin
                    bvalid_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            bundle_reg <= bundle;
        end
        if (load) begin
            m_cmd_reg  <= bundle_reg.slot[idx_reg];
            m_last_reg <= bundle_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_cmd_reg.cmd;
    assign m_tdata  = {m_cmd_reg.glyph, m_cmd_reg.row, m_cmd_reg.col};
    assign m_tlast  = m_last_reg;

endmodule
